FILE: sv/lla_pkg.sv
// Package with the grid constants, rule tables and shared types of the automaton grid.
package lla_pkg;

	// Grid geometry and derived address widths.
	localparam int COLS      = 16;
	localparam int ROWS      = 16;
	localparam int COL_W     = 4;
	localparam int ROW_W     = 4;
	localparam int ROW_AW    = 1 + ROW_W;
	localparam int ROW_DEPTH = 2 * ROWS;
	localparam int AGE_AW    = 1 + ROW_W + COL_W;
	localparam int AGE_DEPTH = 2 * ROWS * COLS;
	localparam int AGE_W     = 8;
	localparam int COUNT_W   = 9;
	localparam int KIND_W    = 2;
	localparam int RULE_W    = 3;
	localparam int RULE_COUNT = 7;
	localparam int MASK_W    = 9;
	localparam int NBR_W     = 4;

	localparam logic [AGE_W-1:0] AGE_MAX = 8'd255;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

	// Rule tables, one bit per neighbor count.
	localparam logic [MASK_W-1:0] BIRTH_ROM [RULE_COUNT] = '{
		9'(1 << 3), 9'(1 << 5), 9'(1 << 6), 9'(1 << 4), 9'(1 << 5),
		9'((1 << 3) | (1 << 6)), 9'(1 << 4)
	};
	localparam logic [MASK_W-1:0] SURVIVE_ROM [RULE_COUNT] = '{
		9'((1 << 2) | (1 << 3)), 9'((1 << 4) | (1 << 5)),
		9'((1 << 5) | (1 << 6) | (1 << 7)), 9'(1 << 5), 9'(1 << 5),
		9'((1 << 2) | (1 << 3)), 9'((1 << 4) | (1 << 5))
	};

	// The unused select code falls back to the first rule.
	function automatic logic [RULE_W-1:0] rule_pick(input logic [RULE_W-1:0] sel);
		return (sel == 3'(RULE_COUNT)) ? '0 : sel;
	endfunction

	function automatic logic [MASK_W-1:0] born_bits(input logic [RULE_W-1:0] sel);
		return BIRTH_ROM[rule_pick(sel)];
	endfunction

	function automatic logic [MASK_W-1:0] kept_bits(input logic [RULE_W-1:0] sel);
		return SURVIVE_ROM[rule_pick(sel)];
	endfunction

	// Access bundle for the live-row memory.
	typedef struct packed {
		logic              we;
		logic [ROW_AW-1:0] waddr;
		logic [COLS-1:0]   wdata;
		logic [ROW_AW-1:0] raddr;
	} row_port_t;

	// Access bundle for the age memory.
	typedef struct packed {
		logic              we;
		logic [AGE_AW-1:0] waddr;
		logic [AGE_W-1:0]  wdata;
		logic [AGE_AW-1:0] raddr;
	} age_port_t;

	// Next state of one cell.
	typedef struct packed {
		logic             alive;
		logic [AGE_W-1:0] age;
	} cell_next_t;

endpackage

FILE: sv/lla_req_if.sv
// Request channel interface: one grid item with valid and ready.
interface lla_req_if;
	logic                          valid;
	logic                          ready;
	logic [lla_pkg::KIND_W-1:0]    kind;
	logic [lla_pkg::COL_W-1:0]     col;
	logic [lla_pkg::ROW_W-1:0]     row;
	logic                          set_alive;
	logic [lla_pkg::AGE_W-1:0]     set_age;

	modport source (output valid, kind, col, row, set_alive, set_age, input ready);
	modport sink (input valid, kind, col, row, set_alive, set_age, output ready);
endinterface

FILE: sv/lla_rsp_if.sv
// Response channel interface: addressed cell and live count with valid and ready.
interface lla_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          got_alive;
	logic [lla_pkg::AGE_W-1:0]     got_age;
	logic [lla_pkg::COUNT_W-1:0]   live_count;

	modport source (output valid, got_alive, got_age, live_count, input ready);
	modport sink (input valid, got_alive, got_age, live_count, output ready);
endinterface

FILE: sv/lla_cfg_if.sv
// Configuration write channel interface: the rule select register.
interface lla_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lla_pkg::RULE_W-1:0]    rule_select;

	modport source (output valid, rule_select, input ready);
	modport sink (input valid, rule_select, output ready);
endinterface

FILE: sv/lla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/lla_cell_eval.sv
// Neighbor count and rule evaluation for one cell from three buffered rows.
module lla_cell_eval (
	input  logic [lla_pkg::COLS-1:0]   up,
	input  logic [lla_pkg::COLS-1:0]   mid,
	input  logic [lla_pkg::COLS-1:0]   dn,
	input  logic [lla_pkg::COL_W-1:0]  col,
	input  logic [lla_pkg::AGE_W-1:0]  age,
	input  logic [lla_pkg::RULE_W-1:0] rule_sel,
	output lla_pkg::cell_next_t        nxt
);

	logic [lla_pkg::COL_W-1:0]  cl;
	logic [lla_pkg::COL_W-1:0]  cr;
	logic [lla_pkg::NBR_W-1:0]  n;
	logic                       was;
	logic [lla_pkg::MASK_W-1:0] mask;

	// Wrapped neighbor columns on the torus.
	assign cl = (col == '0) ? lla_pkg::COL_W'(lla_pkg::COLS - 1) : col - 1'b1;
	assign cr = (col == lla_pkg::COL_W'(lla_pkg::COLS - 1)) ? '0 : col + 1'b1;

	// Count the eight neighbors.
	assign n = lla_pkg::NBR_W'(up[cl]) + lla_pkg::NBR_W'(up[col]) + lla_pkg::NBR_W'(up[cr])
		+ lla_pkg::NBR_W'(mid[cl]) + lla_pkg::NBR_W'(mid[cr])
		+ lla_pkg::NBR_W'(dn[cl]) + lla_pkg::NBR_W'(dn[col]) + lla_pkg::NBR_W'(dn[cr]);

	assign was  = mid[col];
	assign mask = was ? lla_pkg::kept_bits(rule_sel) : lla_pkg::born_bits(rule_sel);

	// Survivors age with saturation; births and deaths restart at zero.
	always_comb begin
		nxt.alive = mask[n];
		if (nxt.alive && was) begin
			nxt.age = (age == lla_pkg::AGE_MAX) ? lla_pkg::AGE_MAX : age + 1'b1;
		end else begin
			nxt.age = '0;
		end
	end

endmodule

FILE: sv/lla_seq.sv
// Sequencer: clearing pass, cell read and write, and the generation sweep over the memories.
module lla_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	lla_req_if.sink                    req,
	lla_rsp_if.source                  rsp,
	input  logic [lla_pkg::RULE_W-1:0] rule_sel,
	output lla_pkg::row_port_t         row_port,
	input  logic [lla_pkg::COLS-1:0]   row_rdata,
	output lla_pkg::age_port_t         age_port,
	input  logic [lla_pkg::AGE_W-1:0]  age_rdata
);

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_WR    = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_AROW  = 3'd4;
	localparam logic [2:0] ST_ACELL = 3'd5;
	localparam logic [2:0] ST_AEND  = 3'd6;
	localparam logic [2:0] ST_AFIN  = 3'd7;
	localparam logic [1:0] SUB_UP   = 2'd0;
	localparam logic [1:0] SUB_MID  = 2'd1;
	localparam logic [1:0] SUB_DN   = 2'd2;
	localparam logic [1:0] SUB_LAST = 2'd3;

	// Control state.
	logic [2:0]                   state_q;
	logic                         fin_q;
	logic [lla_pkg::AGE_AW-1:0]   clr_q;
	logic                         page_q;
	logic [lla_pkg::COUNT_W-1:0]  pop_q;
	logic [1:0]                   sub_q;
	logic [lla_pkg::ROW_W-1:0]    arow_q;
	logic [lla_pkg::COL_W:0]      acol_q;
	logic                         pend_s1;
	logic                         out_valid_q;

	// Payload registers.
	logic [lla_pkg::COL_W-1:0]    col_q;
	logic [lla_pkg::ROW_W-1:0]    row_q;
	logic                         set_alive_q;
	logic [lla_pkg::AGE_W-1:0]    set_age_q;
	logic [lla_pkg::COLS-1:0]     up_q;
	logic [lla_pkg::COLS-1:0]     mid_q;
	logic [lla_pkg::COLS-1:0]     dn_q;
	logic [lla_pkg::COLS-1:0]     nxt_row_q;
	logic [lla_pkg::COL_W-1:0]    pcol_s1;
	logic [lla_pkg::COUNT_W-1:0]  cnt_q;
	logic                         res_alive_q;
	logic [lla_pkg::AGE_W-1:0]    res_age_q;
	logic [lla_pkg::COUNT_W-1:0]  res_count_q;
	logic                         out_alive_q;
	logic [lla_pkg::AGE_W-1:0]    out_age_q;
	logic [lla_pkg::COUNT_W-1:0]  out_count_q;

	logic [lla_pkg::ROW_W-1:0]    row_up;
	logic [lla_pkg::ROW_W-1:0]    row_dn;
	logic [lla_pkg::COLS-1:0]     wr_word;
	logic                         old_bit;
	logic                         out_free;
	lla_pkg::cell_next_t          cell_nxt;

	assign req.ready      = (state_q == ST_IDLE) && !fin_q;
	assign rsp.valid      = out_valid_q;
	assign rsp.got_alive  = out_alive_q;
	assign rsp.got_age    = out_age_q;
	assign rsp.live_count = out_count_q;
	assign out_free       = !out_valid_q || rsp.ready;

	// Wrapped rows above and below the row being computed.
	assign row_up = (arow_q == '0) ? lla_pkg::ROW_W'(lla_pkg::ROWS - 1) : arow_q - 1'b1;
	assign row_dn = (arow_q == lla_pkg::ROW_W'(lla_pkg::ROWS - 1)) ? '0 : arow_q + 1'b1;

	// Row word with the addressed bit replaced by a write request.
	always_comb begin
		wr_word         = row_rdata;
		wr_word[col_q]  = set_alive_q;
	end
	assign old_bit = row_rdata[col_q];

	lla_cell_eval u_eval (
		.up       (up_q),
		.mid      (mid_q),
		.dn       (dn_q),
		.col      (pcol_s1),
		.age      (age_rdata),
		.rule_sel (rule_sel),
		.nxt      (cell_nxt)
	);

	// Memory accesses for each state.
	always_comb begin
		row_port = '0;
		age_port = '0;
		unique case (state_q)
			ST_CLR: begin
				row_port.we    = 1'b1;
				row_port.waddr = clr_q[lla_pkg::ROW_AW-1:0];
				age_port.we    = 1'b1;
				age_port.waddr = clr_q;
			end
			ST_IDLE: begin
				row_port.raddr = {page_q, req.row};
				age_port.raddr = {page_q, req.row, req.col};
			end
			ST_WR: begin
				row_port.we    = 1'b1;
				row_port.waddr = {page_q, row_q};
				row_port.wdata = wr_word;
				age_port.we    = 1'b1;
				age_port.waddr = {page_q, row_q, col_q};
				age_port.wdata = set_age_q;
			end
			ST_AROW: begin
				unique case (sub_q)
					SUB_UP:  row_port.raddr = {page_q, row_up};
					SUB_MID: row_port.raddr = {page_q, arow_q};
					default: row_port.raddr = {page_q, row_dn};
				endcase
			end
			ST_ACELL: begin
				age_port.raddr = {page_q, arow_q, acol_q[lla_pkg::COL_W-1:0]};
				age_port.we    = pend_s1;
				age_port.waddr = {!page_q, arow_q, pcol_s1};
				age_port.wdata = cell_nxt.age;
			end
			ST_AEND: begin
				row_port.we    = 1'b1;
				row_port.waddr = {!page_q, arow_q};
				row_port.wdata = nxt_row_q;
			end
			ST_AFIN: begin
				row_port.raddr = {page_q, row_q};
				age_port.raddr = {page_q, row_q, col_q};
			end
			default: begin
			end
		endcase
	end

	// Control sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			fin_q       <= 1'b0;
			clr_q       <= '0;
			page_q      <= 1'b0;
			pop_q       <= '0;
			sub_q       <= SUB_UP;
			arow_q      <= '0;
			acol_q      <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Output register: a finished result moves in once the slot is free.
			if (fin_q && out_free) begin
				out_valid_q <= 1'b1;
				fin_q       <= 1'b0;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid && !fin_q) begin
						priority if (req.kind == lla_pkg::KIND_ADVANCE) begin
							state_q <= ST_AROW;
							sub_q   <= SUB_UP;
							arow_q  <= '0;
						end else if (req.kind == lla_pkg::KIND_WRITE) begin
							state_q <= ST_WR;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_WR: begin
					pop_q   <= pop_q - lla_pkg::COUNT_W'(old_bit)
						+ lla_pkg::COUNT_W'(set_alive_q);
					fin_q   <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_RD: begin
					fin_q   <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_AROW: begin
					sub_q <= sub_q + 1'b1;
					if (sub_q == SUB_LAST) begin
						state_q <= ST_ACELL;
						acol_q  <= '0;
						pend_s1 <= 1'b0;
					end
				end
				ST_ACELL: begin
					if (acol_q[lla_pkg::COL_W]) begin
						pend_s1 <= 1'b0;
						state_q <= ST_AEND;
					end else begin
						pend_s1 <= 1'b1;
						acol_q  <= acol_q + 1'b1;
					end
				end
				ST_AEND: begin
					if (arow_q == lla_pkg::ROW_W'(lla_pkg::ROWS - 1)) begin
						page_q  <= !page_q;
						pop_q   <= cnt_q;
						state_q <= ST_AFIN;
					end else begin
						arow_q  <= arow_q + 1'b1;
						sub_q   <= SUB_UP;
						state_q <= ST_AROW;
					end
				end
				ST_AFIN: begin
					state_q <= ST_RD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload capture, row buffers and result registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid && !fin_q) begin
			col_q       <= req.col;
			row_q       <= req.row;
			set_alive_q <= req.set_alive;
			set_age_q   <= req.set_age;
			cnt_q       <= '0;
		end
		if (state_q == ST_AROW) begin
			unique case (sub_q)
				SUB_MID:  up_q  <= row_rdata;
				SUB_DN:   mid_q <= row_rdata;
				SUB_LAST: dn_q  <= row_rdata;
				default: begin
				end
			endcase
		end
		if (state_q == ST_ACELL) begin
			pcol_s1 <= acol_q[lla_pkg::COL_W-1:0];
			if (pend_s1) begin
				nxt_row_q[pcol_s1] <= cell_nxt.alive;
				cnt_q              <= cnt_q + lla_pkg::COUNT_W'(cell_nxt.alive);
			end
		end
		if (state_q == ST_WR) begin
			res_alive_q <= set_alive_q;
			res_age_q   <= set_age_q;
			res_count_q <= pop_q - lla_pkg::COUNT_W'(old_bit)
				+ lla_pkg::COUNT_W'(set_alive_q);
		end
		if (state_q == ST_RD) begin
			res_alive_q <= row_rdata[col_q];
			res_age_q   <= age_rdata;
			res_count_q <= pop_q;
		end
		if (fin_q && out_free) begin
			out_alive_q <= res_alive_q;
			out_age_q   <= res_age_q;
			out_count_q <= res_count_q;
		end
	end

endmodule

FILE: sv/life_like_automaton_grid_top.sv
// Top level of the life-like automaton grid: rule register, memories and sequencer.
//
// Channels: req carries one item (write cell, read cell, advance one generation),
// rsp returns the addressed cell of the current page and the live count, one
// response per request, in order. cfg writes rule_select; it is always ready and
// is meant to be written while no request is in flight.
// A read or a write passes through its read or write state and a holding register
// before it reaches the response register. An advance reads the rows above, at and
// below each grid row, walks the age memory at one cell per cycle and writes the
// row back; after the 16-row sweep it reads and reports the cell from the new page.
// Requests are taken one at a time; the next request is accepted while a response
// still waits in the output register, and its result waits in a holding register
// until the receiver takes the previous one, which holds the input off meanwhile.
// Reset: rule_select and the live count clear, page zero becomes current, and a
// clearing pass zeroes both memories; no request is accepted during that pass.
module life_like_automaton_grid_top (
	input  logic      clk,
	input  logic      arst_n,
	lla_req_if.sink   req,
	lla_rsp_if.source rsp,
	lla_cfg_if.sink   cfg
);

	logic [lla_pkg::RULE_W-1:0] rule_q;
	lla_pkg::row_port_t         row_port;
	lla_pkg::age_port_t         age_port;
	logic [lla_pkg::COLS-1:0]   row_rdata;
	logic [lla_pkg::AGE_W-1:0]  age_rdata;

	// Rule select register.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q <= '0;
		end else if (cfg.valid) begin
			rule_q <= cfg.rule_select;
		end
	end

	// Live bits, one grid row per word, two pages.
	lla_ram #(
		.WIDTH (lla_pkg::COLS),
		.DEPTH (lla_pkg::ROW_DEPTH)
	) u_row_ram (
		.clk   (clk),
		.we    (row_port.we),
		.waddr (row_port.waddr),
		.wdata (row_port.wdata),
		.raddr (row_port.raddr),
		.rdata (row_rdata)
	);

	// Cell ages, one cell per word, two pages.
	lla_ram #(
		.WIDTH (lla_pkg::AGE_W),
		.DEPTH (lla_pkg::AGE_DEPTH)
	) u_age_ram (
		.clk   (clk),
		.we    (age_port.we),
		.waddr (age_port.waddr),
		.wdata (age_port.wdata),
		.raddr (age_port.raddr),
		.rdata (age_rdata)
	);

	lla_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rule_sel  (rule_q),
		.row_port  (row_port),
		.row_rdata (row_rdata),
		.age_port  (age_port),
		.age_rdata (age_rdata)
	);

endmodule
